/* rtl/core/tfn_pkg.sv */
// types, widths and helpers shared by the triangle face normal core
package tfn_pkg;

  localparam int COORD_W = 16;
  localparam int FRAC_W  = 14;
  localparam int OUT_W   = FRAC_W + 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int NORM_W  = 31;
  localparam int SQ_W    = 2 * NORM_W;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int SREM_W  = ROOT_W + 3;
  localparam int LEN_W   = 6;
  localparam int QUO_W   = FRAC_W + 1;
  localparam int NUM_W   = NORM_W + QUO_W;
  localparam int FRONT_STAGES = 6;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tfn_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } tfn_out_t;

  // scaled magnitudes and signs handed from front to back
  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   degenerate;
  } tfn_mid_t;

  // bit length of a magnitude, zero for zero
  function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
    logic [LEN_W-1:0] len;
    len = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) len = LEN_W'(i + 1);
    end
    return len;
  endfunction

endpackage

/* rtl/core/triangle_face_normal_core.sv */
// triangle face normal core: top level joining front, queue and back
//
// Takes one triangle (three vertices, signed Q7.8) per request on in_data,
// accepted on a clock edge where start is high and busy is low. Returns the
// unit face normal (signed Q1.14) with a degenerate flag on out_data, marked
// by out_valid for exactly one cycle; the receiver must take it then.
// A degenerate triangle (zero cross product) gives a zero normal and the flag.
// The path runs through 6 front stages, the queue (write and registered read),
// 2 square stages, 32 square-root stages (one root bit each), one rounding
// stage, 15 division stages (one quotient bit each) and the output register.
// Throughput is one triangle per cycle while busy is low; the square-root and
// division pipelines set the latency. busy rises only if the queue between
// front and back holds too many requests, which does not happen in steady
// flow since the back side never stalls.
// Synchronous active-low reset clears all valid flags and the queue;
// requests in flight are dropped.
module triangle_face_normal_core
  import tfn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tfn_in_t  in_data,
  output logic     out_valid,
  output tfn_out_t out_data
);

  logic     f_valid, q_valid;
  tfn_mid_t f_data, q_data;

  tfn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_data   (in_data),
    .mid_valid (f_valid),
    .mid_data  (f_data)
  );

  tfn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .hold_off (busy)
  );

  tfn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (q_valid),
    .mid_data  (q_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/tfn_front.sv */
// front pipeline: edge vectors, cross product, magnitude scaling
module tfn_front
  import tfn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  tfn_in_t  in_data,
  output logic     mid_valid,
  output tfn_mid_t mid_data
);

  logic [FRONT_STAGES-1:0] vld_r;

  logic signed [DIFF_W-1:0]  dx_r, dy_r, dz_r, ex_r, ey_r, ez_r;
  logic signed [PROD_W-1:0]  p_r [0:5];
  logic signed [CROSS_W-1:0] n_r [0:2];
  logic [2:0][MAG_W-1:0]     mag_r, mag2_r;
  logic [2:0]                neg_r, neg2_r;
  logic [MAG_W-1:0]          or_r;
  logic [LEN_W-1:0]          len_r;
  tfn_mid_t                  out_r;
  logic [2:0][MAG_W+NORM_W-1:0] sh;

  // request valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], in_valid};
    end
  end

  // edge vectors d = a - b, e = a - c
  always_ff @(posedge clk) begin
    dx_r <= {in_data.a_x[COORD_W-1], in_data.a_x} - {in_data.b_x[COORD_W-1], in_data.b_x};
    dy_r <= {in_data.a_y[COORD_W-1], in_data.a_y} - {in_data.b_y[COORD_W-1], in_data.b_y};
    dz_r <= {in_data.a_z[COORD_W-1], in_data.a_z} - {in_data.b_z[COORD_W-1], in_data.b_z};
    ex_r <= {in_data.a_x[COORD_W-1], in_data.a_x} - {in_data.c_x[COORD_W-1], in_data.c_x};
    ey_r <= {in_data.a_y[COORD_W-1], in_data.a_y} - {in_data.c_y[COORD_W-1], in_data.c_y};
    ez_r <= {in_data.a_z[COORD_W-1], in_data.a_z} - {in_data.c_z[COORD_W-1], in_data.c_z};
  end

  // partial products of the cross product
  always_ff @(posedge clk) begin
    p_r[0] <= dy_r * ez_r;
    p_r[1] <= dz_r * ey_r;
    p_r[2] <= dz_r * ex_r;
    p_r[3] <= dx_r * ez_r;
    p_r[4] <= dx_r * ey_r;
    p_r[5] <= dy_r * ex_r;
  end

  // cross product components
  always_ff @(posedge clk) begin
    n_r[0] <= {p_r[0][PROD_W-1], p_r[0]} - {p_r[1][PROD_W-1], p_r[1]};
    n_r[1] <= {p_r[2][PROD_W-1], p_r[2]} - {p_r[3][PROD_W-1], p_r[3]};
    n_r[2] <= {p_r[4][PROD_W-1], p_r[4]} - {p_r[5][PROD_W-1], p_r[5]};
  end

  // sign and magnitude, plus the or of magnitudes for the length search
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg_r[i] <= n_r[i][CROSS_W-1];
      mag_r[i] <= n_r[i][CROSS_W-1] ? MAG_W'(-n_r[i]) : MAG_W'(n_r[i]);
    end
    or_r <= (n_r[0][CROSS_W-1] ? MAG_W'(-n_r[0]) : MAG_W'(n_r[0]))
          | (n_r[1][CROSS_W-1] ? MAG_W'(-n_r[1]) : MAG_W'(n_r[1]))
          | (n_r[2][CROSS_W-1] ? MAG_W'(-n_r[2]) : MAG_W'(n_r[2]));
  end

  // bit length of the largest magnitude
  always_ff @(posedge clk) begin
    len_r  <= bit_len(or_r);
    mag2_r <= mag_r;
    neg2_r <= neg_r;
  end

  // scale so the largest magnitude lands in [2^30, 2^31)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = {mag2_r[i], {NORM_W{1'b0}}} >> len_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      out_r.mag[i] <= sh[i][NORM_W-1:0];
    end
    out_r.neg        <= neg2_r;
    out_r.degenerate <= (len_r == '0);
  end

  assign mid_valid = vld_r[FRONT_STAGES-1];
  assign mid_data  = out_r;

endmodule

/* rtl/core/tfn_queue.sv */
// small fifo between front and back pipelines
module tfn_queue
  import tfn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  input  tfn_mid_t wr_data,
  output logic     rd_valid,
  output tfn_mid_t rd_data,
  output logic     hold_off
);

  tfn_mid_t          mem [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              pop;
  logic              rd_valid_r;
  tfn_mid_t          rd_data_r;

  // back side drains one entry every cycle it has one
  assign pop      = (cnt_r != '0);
  assign rd_valid = rd_valid_r;
  assign rd_data  = rd_data_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_valid && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!wr_valid && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      rd_valid_r <= pop;
      if (wr_valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)      rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // storage with registered read
  always_ff @(posedge clk) begin
    if (wr_valid) mem[wr_ptr_r] <= wr_data;
    if (pop)      rd_data_r <= mem[rd_ptr_r];
  end

  // leave room for every request still in the front pipeline
  assign hold_off = (cnt_r >= (QPTR_W+1)'(QUEUE_DEPTH - FRONT_STAGES));

endmodule

/* rtl/core/tfn_back.sv */
// back pipeline: length by square root, then per-component division
module tfn_back
  import tfn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     mid_valid,
  input  tfn_mid_t mid_data,
  output logic     out_valid,
  output tfn_out_t out_data
);

  localparam int NSQ  = ROOT_W;
  localparam int NDIV = QUO_W;

  // squares
  logic [2:0][SQ_W-1:0] sq_r;
  tfn_mid_t             sqm_r;
  logic                 sqv_r;

  // square root stages
  logic [SUM_W-1:0]  sx_r   [0:NSQ];
  logic [SREM_W-1:0] srem_r [0:NSQ];
  logic [ROOT_W-1:0] sroot_r[0:NSQ];
  tfn_mid_t          sm_r   [0:NSQ];
  logic [NSQ:0]      sv_r;

  // division stages
  logic [ROOT_W-1:0]      dr_r  [0:NDIV];
  logic [2:0][ROOT_W-1:0] drem_r[0:NDIV];
  logic [2:0][QUO_W-1:0]  dnum_r[0:NDIV];
  logic [2:0][QUO_W-1:0]  dq_r  [0:NDIV];
  logic [2:0]             dneg_r[0:NDIV];
  logic                   ddeg_r[0:NDIV];
  logic [NDIV:0]          dv_r;

  tfn_out_t               res_r;
  logic                   resv_r;
  logic [2:0][NUM_W-1:0]  num;
  logic [2:0][QUO_W-1:0]  qc;
  logic [2:0][OUT_W-1:0]  qs;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= mid_data.mag[i] * mid_data.mag[i];
    end
    sqm_r <= mid_data;
  end

  // sum of squares seeds the root pipeline
  always_ff @(posedge clk) begin
    sx_r[0]    <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    srem_r[0]  <= '0;
    sroot_r[0] <= '0;
    sm_r[0]    <= sqm_r;
  end

  // one root bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [SREM_W-1:0] rs, tr;
    assign rs = {srem_r[k][SREM_W-3:0], sx_r[k][SUM_W-1 -: 2]};
    assign tr = SREM_W'({sroot_r[k], 2'b01});
    always_ff @(posedge clk) begin
      sx_r[k+1] <= {sx_r[k][SUM_W-3:0], 2'b00};
      sm_r[k+1] <= sm_r[k];
      if (rs >= tr) begin
        srem_r[k+1]  <= rs - tr;
        sroot_r[k+1] <= {sroot_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        srem_r[k+1]  <= rs;
        sroot_r[k+1] <= {sroot_r[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // rounded numerators m * 2^F + R/2, top part seeds the remainder
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {sm_r[NSQ].mag[i], {QUO_W{1'b0}}} >> 1;
      num[i] = num[i] + NUM_W'(sroot_r[NSQ] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    dr_r[0]   <= sroot_r[NSQ];
    dneg_r[0] <= sm_r[NSQ].neg;
    ddeg_r[0] <= sm_r[NSQ].degenerate;
    for (int i = 0; i < 3; i++) begin
      drem_r[0][i] <= ROOT_W'(num[i][NUM_W-1:QUO_W]);
      dnum_r[0][i] <= num[i][QUO_W-1:0];
      dq_r[0][i]   <= '0;
    end
  end

  // one quotient bit per stage, three lanes
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [2:0][ROOT_W:0] t;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {drem_r[j][i], dnum_r[j][i][QUO_W-1]};
      end
    end
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        dnum_r[j+1][i] <= {dnum_r[j][i][QUO_W-2:0], 1'b0};
        if (t[i] >= {1'b0, dr_r[j]}) begin
          drem_r[j+1][i] <= ROOT_W'(t[i] - {1'b0, dr_r[j]});
          dq_r[j+1][i]   <= {dq_r[j][i][QUO_W-2:0], 1'b1};
        end else begin
          drem_r[j+1][i] <= ROOT_W'(t[i]);
          dq_r[j+1][i]   <= {dq_r[j][i][QUO_W-2:0], 1'b0};
        end
      end
      dr_r[j+1]   <= dr_r[j];
      dneg_r[j+1] <= dneg_r[j];
      ddeg_r[j+1] <= ddeg_r[j];
    end
  end

  // clamp to one, apply sign, zero on a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dq_r[NDIV][i] > QUO_W'(1 << FRAC_W)) ? QUO_W'(1 << FRAC_W) : dq_r[NDIV][i];
      qs[i] = dneg_r[NDIV][i] ? -OUT_W'(qc[i]) : OUT_W'(qc[i]);
      if (ddeg_r[NDIV]) qs[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    res_r.normal_x   <= qs[0];
    res_r.normal_y   <= qs[1];
    res_r.normal_z   <= qs[2];
    res_r.degenerate <= ddeg_r[NDIV];
  end

  // valid chain for the whole back pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r  <= 1'b0;
      sv_r   <= '0;
      dv_r   <= '0;
      resv_r <= 1'b0;
    end else begin
      sqv_r  <= mid_valid;
      sv_r   <= {sv_r[NSQ-1:0], sqv_r};
      dv_r   <= {dv_r[NDIV-1:0], sv_r[NSQ]};
      resv_r <= dv_r[NDIV];
    end
  end

  assign out_valid = resv_r;
  assign out_data  = res_r;

endmodule
